// ----- sv/wdb_pkg.sv -----
package wdb_pkg;

  // Field and datapath widths
  localparam int R2W = 23;        // squared bin radius, integer
  localparam int RW = 28;         // radius, 16 fractional bits
  localparam int DIV_LAT = 36;    // register stages through wdb_div
  localparam int Q_DEPTH = 4;     // front-to-back and result queues

  // Defaults for top-level parameters
  localparam int OTF_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_FILTER = 1'b1;

  typedef enum logic [2:0] {
    REG_ROW_COUNT = 3'd0,
    REG_WIENER_SQ = 3'd1,
    REG_RADIUS_SCALE = 3'd2,
    REG_CUTOFF_RADIUS = 3'd3,
    REG_CUTOFF_RECIP = 3'd4
  } cfg_reg_e;

  localparam logic [10:0] RST_ROW_COUNT = 11'd512;
  localparam logic [31:0] RST_WIENER_SQ = 32'd175922;
  localparam logic [23:0] RST_RADIUS_SCALE = 24'd65536;
  localparam logic [18:0] RST_CUTOFF_RADIUS = 19'd51200;
  localparam logic [24:0] RST_CUTOFF_RECIP = 25'd83886;

  typedef struct packed {
    logic [10:0] row_count;
    logic [31:0] wiener_sq;
    logic [23:0] radius_scale;
    logic [18:0] cutoff_radius;
    logic [24:0] cutoff_reciprocal;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic               kind;
    logic               band;
    logic [R2W-1:0]     r2;
    logic [9:0]         table_index;
    logic signed [23:0] otf_re;
    logic signed [23:0] otf_im;
    logic signed [31:0] data_re;
    logic signed [31:0] data_im;
  } job_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               in_band;
    logic               clipped;
  } result_t;

endpackage

// ----- sv/wdb_fifo.sv -----
module wdb_fifo import wdb_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0] cnt;
  logic do_push;
  logic do_pop;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(DEPTH)) else $error("queue count above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && !empty)) |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count missed a push");

  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !(push && !full)) |=> cnt == $past(cnt) - 1'b1)
    else $error("queue count missed a pop");

endmodule

// ----- sv/wdb_front.sv -----
module wdb_front import wdb_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic [9:0]         table_index,
  input  logic signed [23:0] otf_re,
  input  logic signed [23:0] otf_im,
  input  logic [9:0]         row,
  input  logic [9:0]         col,
  input  logic signed [31:0] data_re,
  input  logic signed [31:0] data_im,
  output logic               q_push,
  input  logic               q_full,
  output job_t               q_job
);

  logic f_en;
  logic s1_v, s2_v, s3_v;
  job_t s1_job, s2_job, s3_job;
  job_t s2_out;
  logic [9:0] s1_row, s1_col, s2_col;
  logic signed [11:0] s2_off;
  logic [10:0] rows;
  logic signed [11:0] off;
  logic signed [23:0] off_sq;
  logic [19:0] col_sq;
  logic [37:0] cutoff_sq;
  job_t in_job;

  // Whole front advances together; it holds only when its last stage cannot leave
  assign f_en = !(s3_v && q_full);
  assign full = !f_en;
  assign q_push = s3_v && !q_full;

  always_comb begin
    in_job = '0;
    in_job.kind = kind;
    in_job.table_index = table_index;
    in_job.otf_re = otf_re;
    in_job.otf_im = otf_im;
    in_job.data_re = data_re;
    in_job.data_im = data_im;
  end

  // Signed row offset: rows above half wrap negative
  always_comb begin
    rows = (32'(cfg.row_count) > MAX_ROWS) ? 11'(MAX_ROWS) : cfg.row_count;
    if (11'(s1_row) > (rows >> 1)) begin
      off = $signed(12'(s1_row)) - $signed(12'(rows));
    end else begin
      off = $signed(12'(s1_row));
    end
  end

  assign off_sq = s2_off * s2_off;
  assign col_sq = 20'(s2_col) * 20'(s2_col);

  // Squared radius joins the job on its way to the last stage
  always_comb begin
    s2_out = s2_job;
    s2_out.r2 = R2W'(off_sq) + R2W'(col_sq);
  end

  // Band test against the squared cutoff
  always_comb begin
    q_job = s3_job;
    q_job.band = ({s3_job.r2, 16'b0} <= 39'(cutoff_sq));
  end

  always_ff @(posedge clk) begin
    cutoff_sq <= 38'(cfg.cutoff_radius) * 38'(cfg.cutoff_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (f_en) begin
      s1_v <= push;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      s1_job <= in_job;
      s1_row <= row;
      s1_col <= col;
      s2_job <= s1_job;
      s2_off <= off;
      s2_col <= s1_col;
      s3_job <= s2_out;
    end
  end

endmodule

// ----- sv/wdb_div.sv -----
module wdb_div import wdb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [56:0] mag,
  input  logic        neg,
  input  logic [24:0] taper,
  input  logic [47:0] denom,
  output logic [31:0] res,
  output logic        clip
);

  // floor(mag*taper / (4*denom)), signed and saturated to 32 bits
  localparam int QB = 32;

  logic [56:0] pl;
  logic [49:0] ph;
  logic [49:0] dd0, dd1;
  logic neg0, neg1, dz0, dz1;
  logic [81:0] prod;

  logic [49:0] dv_rem [QB+1];
  logic [31:0] dv_lo  [QB+1];
  logic [31:0] dv_q   [QB+1];
  logic [49:0] dv_dd  [QB+1];
  logic        dv_ovf [QB+1];
  logic        dv_neg [QB+1];
  logic        dv_dz  [QB+1];

  // Partial products, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      pl <= 57'(mag[31:0]) * 57'(taper);
      ph <= 50'(mag[56:32]) * 50'(taper);
      dd0 <= {denom, 2'b00};
      neg0 <= neg;
      dz0 <= (denom == '0);
      prod <= {ph, 32'b0} + 82'(pl);
      dd1 <= dd0;
      neg1 <= neg0;
      dz1 <= dz0;
    end
  end

  // Overflow when the quotient reaches 2^32; else the top part seeds the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= prod[81:32];
      dv_lo[0] <= prod[31:0];
      dv_q[0] <= '0;
      dv_dd[0] <= dd1;
      dv_ovf[0] <= (prod[81:32] >= dd1);
      dv_neg[0] <= neg1;
      dv_dz[0] <= dz1;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [50:0] rt;
    logic ge;
    assign rt = {dv_rem[k], dv_lo[k][31]};
    assign ge = (rt >= {1'b0, dv_dd[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1] <= ge ? 50'(rt - {1'b0, dv_dd[k]}) : rt[49:0];
        dv_lo[k+1] <= {dv_lo[k][30:0], 1'b0};
        dv_q[k+1] <= {dv_q[k][30:0], ge};
        dv_dd[k+1] <= dv_dd[k];
        dv_ovf[k+1] <= dv_ovf[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_dz[k+1] <= dv_dz[k];
      end
    end
  end

  // Sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_dz[QB]) begin
        res <= '0;
        clip <= 1'b0;
      end else if (!dv_neg[QB]) begin
        if (dv_ovf[QB] || dv_q[QB][31]) begin
          res <= 32'h7FFF_FFFF;
          clip <= 1'b1;
        end else begin
          res <= dv_q[QB];
          clip <= 1'b0;
        end
      end else begin
        if (dv_ovf[QB] || (dv_q[QB] > 32'h8000_0000)) begin
          res <= 32'h8000_0000;
          clip <= 1'b1;
        end else begin
          res <= 32'd0 - dv_q[QB];
          clip <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/wdb_back.sv -----
module wdb_back import wdb_pkg::*; #(
  parameter int OTF_DEPTH = OTF_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  job_t    q_job,
  output logic    q_pop,
  input  logic    out_full,
  output logic    res_v,
  output result_t res
);

  localparam int AW = $clog2(OTF_DEPTH);

  logic en;

  // Square root stages
  logic              sq_v    [RW+1];
  logic [2*RW-1:0]   sq_x    [RW+1];
  logic [RW:0]       sq_rem  [RW+1];
  logic [RW-1:0]     sq_root [RW+1];
  job_t              sq_job  [RW+1];

  logic m1_v, m2_v, m3_v, m4_v, m5_v, m6_v, m7_v;
  job_t m1_job, m2_job, m3_job, m4_job, m5_job, m6_job, m7_job;
  logic [51:0] pos;
  logic [52:0] rq;
  logic [19:0] idx;
  logic [20:0] idx1;
  logic [36:0] rq_s;
  logic [24:0] taper_c;
  logic [15:0] frac2;
  logic [24:0] taper2, taper3, taper4, taper5, taper6, taper7;
  logic ok_a, ok_b;
  logic [47:0] otf_mem [OTF_DEPTH];
  logic [47:0] rd_a, rd_b;
  logic signed [23:0] a_re, a_im, b_re, b_im;
  logic signed [17:0] wa, wb;
  logic signed [41:0] pa_re, pb_re, pa_im, pb_im;
  logic signed [42:0] s_re, s_im;
  logic signed [23:0] o_re, o_im;
  logic signed [47:0] sq_re, sq_im;
  logic signed [55:0] p_rr, p_ii, p_ri, p_ir;
  logic [47:0] denom6, denom7;
  logic signed [56:0] n_re, n_im;
  logic [56:0] mag_re, mag_im;
  logic neg_re, neg_im;
  logic wr_ok;

  logic tg_v    [DIV_LAT+1];
  logic tg_kind [DIV_LAT+1];
  logic tg_band [DIV_LAT+1];
  logic [31:0] dres_re, dres_im;
  logic dclip_re, dclip_im;

  // Whole back advances unless a finished result cannot enter the output queue
  assign en = !(res_v && out_full);
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0] <= {1'b0, q_job.r2, 32'b0};
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      sq_job[0] <= q_job;
    end
  end

  // Digit-by-digit integer square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+2:0] rt;
    logic [RW+2:0] tr;
    logic ge;
    assign rt = {sq_rem[k], sq_x[k][2*RW-1 -: 2]};
    assign tr = {1'b0, sq_root[k], 2'b01};
    assign ge = (rt >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[k+1] <= {sq_x[k][2*RW-3:0], 2'b00};
        sq_rem[k+1] <= ge ? (RW+1)'(rt - tr) : rt[RW:0];
        sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
        sq_job[k+1] <= sq_job[k];
      end
    end
  end

  // Table position, taper and table access
  assign idx = pos[51:32];
  assign idx1 = 21'(idx) + 21'd1;
  assign rq_s = rq[52:16];
  assign taper_c = (rq_s >= 37'h100_0000) ? '0 : 25'(37'h100_0000 - rq_s);
  assign wr_ok = (32'(m1_job.table_index) < OTF_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= 52'(sq_root[RW]) * 52'(cfg.radius_scale);
      rq <= 53'(sq_root[RW]) * 53'(cfg.cutoff_reciprocal);
      m1_job <= sq_job[RW];
      frac2 <= pos[31:16];
      taper2 <= taper_c;
      ok_a <= (32'(idx) < OTF_DEPTH);
      ok_b <= (32'(idx1) < OTF_DEPTH);
      m2_job <= m1_job;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (m1_v && (m1_job.kind == KIND_LOAD) && wr_ok) begin
        otf_mem[AW'(m1_job.table_index)] <= {m1_job.otf_re, m1_job.otf_im};
      end
      rd_a <= otf_mem[AW'(idx)];
      rd_b <= otf_mem[AW'(idx1)];
    end
  end

  // Linear interpolation between neighboring entries
  assign a_re = ok_a ? $signed(rd_a[47:24]) : '0;
  assign a_im = ok_a ? $signed(rd_a[23:0]) : '0;
  assign b_re = ok_b ? $signed(rd_b[47:24]) : '0;
  assign b_im = ok_b ? $signed(rd_b[23:0]) : '0;
  assign wa = $signed(18'(17'h1_0000 - 17'(frac2)));
  assign wb = $signed(18'(frac2));
  assign s_re = 43'(pa_re) + 43'(pb_re);
  assign s_im = 43'(pa_im) + 43'(pb_im);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_re <= a_re * wa;
      pb_re <= b_re * wb;
      pa_im <= a_im * wa;
      pb_im <= b_im * wb;
      taper3 <= taper2;
      m3_job <= m2_job;
      o_re <= s_re[39:16];
      o_im <= s_im[39:16];
      taper4 <= taper3;
      m4_job <= m3_job;
    end
  end

  // Magnitude, numerator and denominator
  always_ff @(posedge clk) begin
    if (en) begin
      sq_re <= o_re * o_re;
      sq_im <= o_im * o_im;
      p_rr <= 56'(o_re) * 56'(m4_job.data_re);
      p_ii <= 56'(o_im) * 56'(m4_job.data_im);
      p_ri <= 56'(o_re) * 56'(m4_job.data_im);
      p_ir <= 56'(o_im) * 56'(m4_job.data_re);
      taper5 <= taper4;
      m5_job <= m4_job;
      denom6 <= 48'(sq_re) + 48'(sq_im) + 48'(cfg.wiener_sq);
      n_re <= 57'(p_rr) + 57'(p_ii);
      n_im <= 57'(p_ri) - 57'(p_ir);
      taper6 <= taper5;
      m6_job <= m5_job;
      mag_re <= n_re[56] ? 57'(-n_re) : 57'(n_re);
      mag_im <= n_im[56] ? 57'(-n_im) : 57'(n_im);
      neg_re <= n_re[56];
      neg_im <= n_im[56];
      denom7 <= denom6;
      taper7 <= taper6;
      m7_job <= m6_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= RW; i++) begin
        sq_v[i] <= 1'b0;
      end
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
      m5_v <= 1'b0;
      m6_v <= 1'b0;
      m7_v <= 1'b0;
    end else if (en) begin
      sq_v[0] <= q_pop;
      for (int i = 0; i < RW; i++) begin
        sq_v[i+1] <= sq_v[i];
      end
      m1_v <= sq_v[RW];
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
      m5_v <= m4_v;
      m6_v <= m5_v;
      m7_v <= m6_v;
    end
  end

  wdb_div u_div_re (
    .clk   (clk),
    .en    (en),
    .mag   (mag_re),
    .neg   (neg_re),
    .taper (taper7),
    .denom (denom7),
    .res   (dres_re),
    .clip  (dclip_re)
  );

  wdb_div u_div_im (
    .clk   (clk),
    .en    (en),
    .mag   (mag_im),
    .neg   (neg_im),
    .taper (taper7),
    .denom (denom7),
    .res   (dres_im),
    .clip  (dclip_im)
  );

  // Control delay line alongside the dividers
  assign tg_v[0] = m7_v;
  assign tg_kind[0] = m7_job.kind;
  assign tg_band[0] = m7_job.band;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        tg_v[k+1] <= 1'b0;
      end else if (en) begin
        tg_v[k+1] <= tg_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tg_kind[k+1] <= tg_kind[k];
        tg_band[k+1] <= tg_band[k];
      end
    end
  end

  // Out-of-band bins give zero
  assign res_v = tg_v[DIV_LAT] && (tg_kind[DIV_LAT] == KIND_FILTER);
  always_comb begin
    res.in_band = tg_band[DIV_LAT];
    res.out_re = tg_band[DIV_LAT] ? $signed(dres_re) : '0;
    res.out_im = tg_band[DIV_LAT] ? $signed(dres_im) : '0;
    res.clipped = tg_band[DIV_LAT] && (dclip_re || dclip_im);
  end

endmodule

// ----- sv/wiener_deconvolution_bin.sv -----
// Radial Wiener filter for frequency bins.
// Input queue side: an item is transferred when push is high and full is low.
// kind selects a table load (table_index, otf_re, otf_im) or a bin to filter
// (row, col, data_re, data_im). Loads give no result; each filter item gives
// one result on the output queue side (out_re, out_im, in_band, clipped),
// shown while empty is low and transferred when pop is high.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index
// (0 row_count, 1 wiener_sq, 2 radius_scale, 3 cutoff_radius,
// 4 cutoff_reciprocal); cfg_ready is always high. Write only while idle.
// Throughput is one item per cycle while full is low. The path from input
// transfer to the result showing runs through the 28-stage square root and
// the two 36-stage multiply-divide pipelines.
// Reset clears both queues and all pipeline valids and loads the registers'
// reset values; the OTF table is not cleared and must be loaded before use.
// When pop stays low the result queue fills, the back pipeline freezes, then
// the middle queue and front fill and full rises; nothing is dropped.
module wiener_deconvolution_bin import wdb_pkg::*; #(
  parameter int OTF_DEPTH = OTF_DEPTH_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic [9:0]         table_index,
  input  logic signed [23:0] otf_re,
  input  logic signed [23:0] otf_im,
  input  logic [9:0]         row,
  input  logic [9:0]         col,
  input  logic signed [31:0] data_re,
  input  logic signed [31:0] data_im,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_re,
  output logic signed [31:0] out_im,
  output logic               in_band,
  output logic               clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t cfg;
  logic fq_push, fq_full, fq_empty, fq_pop;
  job_t fq_wjob, fq_rjob;
  logic res_v, out_full;
  result_t res, out_res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count <= RST_ROW_COUNT;
      cfg.wiener_sq <= RST_WIENER_SQ;
      cfg.radius_scale <= RST_RADIUS_SCALE;
      cfg.cutoff_radius <= RST_CUTOFF_RADIUS;
      cfg.cutoff_reciprocal <= RST_CUTOFF_RECIP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ROW_COUNT:     cfg.row_count <= cfg_data[10:0];
        REG_WIENER_SQ:     cfg.wiener_sq <= cfg_data;
        REG_RADIUS_SCALE:  cfg.radius_scale <= cfg_data[23:0];
        REG_CUTOFF_RADIUS: cfg.cutoff_radius <= cfg_data[18:0];
        REG_CUTOFF_RECIP:  cfg.cutoff_reciprocal <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  wdb_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .table_index (table_index),
    .otf_re      (otf_re),
    .otf_im      (otf_im),
    .row         (row),
    .col         (col),
    .data_re     (data_re),
    .data_im     (data_im),
    .q_push      (fq_push),
    .q_full      (fq_full),
    .q_job       (fq_wjob)
  );

  wdb_fifo #(.W($bits(job_t)), .DEPTH(Q_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_wjob),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rjob)
  );

  wdb_back #(.OTF_DEPTH(OTF_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (fq_empty),
    .q_job    (fq_rjob),
    .q_pop    (fq_pop),
    .out_full (out_full),
    .res_v    (res_v),
    .res      (res)
  );

  wdb_fifo #(.W($bits(result_t)), .DEPTH(Q_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_v),
    .full  (out_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (out_res)
  );

  assign out_re = out_res.out_re;
  assign out_im = out_res.out_im;
  assign in_band = out_res.in_band;
  assign clipped = out_res.clipped;

endmodule
